>>> hw/rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 digest package
// Shared types, round constants, initial hash values and mixing functions.
// ----------------------------------------------------------------------------
package smd_pkg;

	localparam int WordW   = 64;
	localparam int Rounds  = 80;
	localparam int BlkWrds = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic absorb;     // take one request chunk into the gather buffer
		logic pad;        // write one padding or length word
		logic load_work;  // copy chaining value into working variables
		logic round;      // run one compression round
		logic add_chain;  // fold working variables into chaining value
		logic out_next;   // one digest word was taken
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic absorb_fills; // the chunk being absorbed completes a block
		logic pad_fills;    // the padding word being written completes a block
		logic len_done;     // the block just compressed carried the length
		logic round_last;   // current round is the last one
		logic out_last;     // current digest word is the last one
	} sts_t;

	localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam logic [WordW-1:0] INIT_H [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
		big_sig0 = {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
	endfunction

	function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
		big_sig1 = {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
	endfunction

	function automatic logic [WordW-1:0] sml_sig0(input logic [WordW-1:0] x);
		sml_sig0 = {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
	endfunction

	function automatic logic [WordW-1:0] sml_sig1(input logic [WordW-1:0] x);
		sml_sig1 = {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
	endfunction

endpackage

>>> hw/rtl/sha512_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-512 message digest
// Hashes a byte stream delivered in chunks and returns eight digest words.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel carries up to BYTES_PER_ITEM
// message bytes, left-aligned in chunk_data, with valid_bytes giving how many
// count (larger values saturate). end_of_message marks the last request of a
// message; a request with zero bytes and end_of_message closes the message.
// An input request is taken whenever the block is idle. Every sixteenth full
// 64-bit word triggers a compression (a load of the working variables, 80
// rounds at one round per cycle in the shared round unit, and a chaining add),
// during which in_stall stays high, so no new request is taken.
// After the last request the block writes padding and the length one word
// per cycle, runs one or two more compressions, then presents the digest as
// eight requests on the output channel, most significant word first, with
// last_word on the eighth. A high out_stall simply holds the current word;
// input stays stalled until all eight words are taken, then the block starts
// a fresh message. Reset loads the initial hash values and clears all
// counters; the first request may be accepted in the cycle after reset.
// ----------------------------------------------------------------------------
module sha512_message_digest
	import smd_pkg::*;
#(
	parameter int BYTES_PER_ITEM = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [8*BYTES_PER_ITEM-1:0] chunk_data,
	input  logic [3:0]                  valid_bytes,
	input  logic                        end_of_message,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [WordW-1:0]            digest_word,
	output logic [2:0]                  digest_index,
	output logic                        last_word
);

	// Commands flow from the controller, status flows back from the datapath.
	cmd_t cmd;
	sts_t sts;

	smd_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sts            (sts),
		.cmd            (cmd)
	);

	// The datapath holds the gather buffer, schedule window and hash state.
	smd_datapath #(
		.BYTES_PER_ITEM (BYTES_PER_ITEM)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.chunk_data     (chunk_data),
		.valid_bytes    (valid_bytes),
		.end_of_message (end_of_message),
		.cmd            (cmd),
		.sts            (sts),
		.digest_word    (digest_word),
		.digest_index   (digest_index),
		.last_word      (last_word)
	);

endmodule

>>> hw/rtl/smd_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-512 digest controller
// Sequences absorb, padding, compression and digest output.
// ----------------------------------------------------------------------------
module smd_ctrl
	import smd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic end_of_message,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       end_q, end_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		end_d   = end_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.absorb = 1'b1;
					end_d      = end_of_message;
					if (sts.absorb_fills) begin
						state_d = ST_LOAD;
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.pad = 1'b1;
				if (sts.pad_fills) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_work = 1'b1;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (sts.round_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_chain = 1'b1;
				if (!end_q) begin
					state_d = ST_IDLE;
				end else if (sts.len_done) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					cmd.out_next = 1'b1;
					if (sts.out_last) begin
						state_d = ST_IDLE;
						end_d   = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			end_q   <= end_d;
		end
	end

endmodule

>>> hw/rtl/smd_datapath.sv
// ----------------------------------------------------------------------------
// SHA-512 digest datapath
// Byte gathering, message schedule window, round logic and chaining value.
// ----------------------------------------------------------------------------
module smd_datapath
	import smd_pkg::*;
#(
	parameter int BYTES_PER_ITEM = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [8*BYTES_PER_ITEM-1:0] chunk_data,
	input  logic [3:0]                  valid_bytes,
	input  logic                        end_of_message,
	input  cmd_t                        cmd,
	output sts_t                        sts,
	output logic [WordW-1:0]            digest_word,
	output logic [2:0]                  digest_index,
	output logic                        last_word
);

	localparam int DataW = 8 * BYTES_PER_ITEM;
	localparam int AlignSh = WordW - DataW;

	logic [WordW-1:0] win_q   [BlkWrds];
	logic [WordW-1:0] work_q  [8];
	logic [WordW-1:0] chain_q [8];
	logic [WordW-1:0] pend_q;
	logic [2:0]       pend_cnt_q;
	logic [3:0]       widx_q;
	logic [60:0]      count_q;
	logic [6:0]       round_q;
	logic [2:0]       out_idx_q;
	logic             pad_first_q;
	logic             len_phase_q;
	logic             len_done_q;

	// Chunk alignment and merge with the partial word.
	logic [3:0]         n_sat;
	logic [WordW-1:0]   new_al;
	logic [WordW-1:0]   new_msk;
	logic [2*WordW-1:0] merged;
	logic [3:0]         total;
	logic               word_done;

	always_comb begin
		n_sat     = (valid_bytes > 4'(BYTES_PER_ITEM)) ? 4'(BYTES_PER_ITEM) : valid_bytes;
		new_al    = WordW'(chunk_data) << AlignSh;
		new_msk   = new_al & ~({WordW{1'b1}} >> {n_sat, 3'b000});
		merged    = {pend_q, {WordW{1'b0}}} | ({new_msk, {WordW{1'b0}}} >> {pend_cnt_q, 3'b000});
		total     = {1'b0, pend_cnt_q} + n_sat;
		word_done = total[3];
	end

	// Padding word selection.
	logic [WordW-1:0] pad_word;

	always_comb begin
		if (pad_first_q) begin
			pad_word = pend_q | ({56'd0, 8'h80} << {(3'd7 - pend_cnt_q), 3'b000});
		end else if (widx_q == 4'd15 && len_phase_q) begin
			pad_word = {count_q, 3'b000};
		end else begin
			pad_word = '0;
		end
	end

	// One compression round.
	logic [WordW-1:0] w_cur;
	logic [WordW-1:0] t1;
	logic [WordW-1:0] t2;

	always_comb begin
		if (round_q < 7'd16) begin
			w_cur = win_q[0];
		end else begin
			w_cur = sml_sig1(win_q[14]) + win_q[9] + sml_sig0(win_q[1]) + win_q[0];
		end
		t1 = work_q[7] + big_sig1(work_q[4])
		   + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		   + ROUND_K[round_q] + w_cur;
		t2 = big_sig0(work_q[0])
		   + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
	end

	assign sts.absorb_fills = word_done && (widx_q == 4'd15);
	assign sts.pad_fills    = (widx_q == 4'd15);
	assign sts.len_done     = len_done_q;
	assign sts.round_last   = (round_q == 7'(Rounds - 1));
	assign sts.out_last     = (out_idx_q == 3'd7);

	assign digest_word  = chain_q[out_idx_q];
	assign digest_index = out_idx_q;
	assign last_word    = (out_idx_q == 3'd7);

	// Schedule window: written by absorb and padding, shifted by rounds.
	always_ff @(posedge clk) begin
		if (cmd.absorb && word_done) begin
			win_q[widx_q] <= merged[2*WordW-1:WordW];
		end else if (cmd.pad) begin
			win_q[widx_q] <= pad_word;
		end else if (cmd.round) begin
			for (int i = 0; i < BlkWrds - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BlkWrds-1] <= w_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i]  <= '0;
				chain_q[i] <= INIT_H[i];
			end
			pend_q      <= '0;
			pend_cnt_q  <= '0;
			widx_q      <= '0;
			count_q     <= '0;
			round_q     <= '0;
			out_idx_q   <= '0;
			pad_first_q <= 1'b0;
			len_phase_q <= 1'b0;
			len_done_q  <= 1'b0;
		end else begin
			if (cmd.absorb) begin
				count_q     <= count_q + 61'(n_sat);
				pad_first_q <= end_of_message;
				if (word_done) begin
					pend_q     <= merged[WordW-1:0];
					pend_cnt_q <= total[2:0];
					widx_q     <= widx_q + 4'd1;
				end else begin
					pend_q     <= merged[2*WordW-1:WordW];
					pend_cnt_q <= total[2:0];
				end
			end
			if (cmd.pad) begin
				widx_q      <= widx_q + 4'd1;
				pad_first_q <= 1'b0;
				if (pad_first_q) begin
					pend_q     <= '0;
					pend_cnt_q <= '0;
				end else if (widx_q == 4'd14) begin
					len_phase_q <= 1'b1;
				end else if (widx_q == 4'd15 && len_phase_q) begin
					len_done_q <= 1'b1;
				end
			end
			if (cmd.load_work) begin
				for (int i = 0; i < 8; i++) begin
					work_q[i] <= chain_q[i];
				end
			end
			if (cmd.round) begin
				work_q[7] <= work_q[6];
				work_q[6] <= work_q[5];
				work_q[5] <= work_q[4];
				work_q[4] <= work_q[3] + t1;
				work_q[3] <= work_q[2];
				work_q[2] <= work_q[1];
				work_q[1] <= work_q[0];
				work_q[0] <= t1 + t2;
				round_q   <= sts.round_last ? 7'd0 : round_q + 7'd1;
			end
			if (cmd.add_chain) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
			if (cmd.out_next) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (sts.out_last) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= INIT_H[i];
					end
					count_q     <= '0;
					len_phase_q <= 1'b0;
					len_done_q  <= 1'b0;
				end
			end
		end
	end

endmodule

>>> sim/sha512_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 digest checker
// Watches both channels of the digest block and predicts every digest word
// from the accepted requests. Each word that leaves the block is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sha512_digest_checker
	import smd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] chunk_data,
	input  logic [3:0]  valid_bytes,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] digest_word,
	input  logic [2:0]  digest_index,
	input  logic        last_word,
	output int          errors,
	output int          pending,
	output int          digests_seen
);

	typedef struct {
		logic [63:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	digest_word_t digest_q[$];

	logic [63:0] hash_state [8];
	logic [63:0] block_words [16];
	int unsigned block_pos;
	logic [60:0] byte_count;

	initial begin
		errors       = 0;
		pending      = 0;
		digests_seen = 0;
	end

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] digest mismatch: %s", $realtime, what);
		errors++;
	endtask

	// One SHA-512 compression over the gathered block, schedule kept in place.
	task automatic compress_block();
		logic [63:0] v [8];
		logic [63:0] x, y, s0, s1, t1, t2;
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int t = 0; t < Rounds; t++) begin
			if (t >= 16) begin
				x = block_words[(t + 1) % 16];
				y = block_words[(t + 14) % 16];
				s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
				s1 = rotr(y, 19) ^ rotr(y, 61) ^ (y >> 6);
				block_words[t % 16] = block_words[t % 16] + s0 + block_words[(t + 9) % 16] + s1;
			end
			t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
			   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + block_words[t % 16];
			t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
			   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		int unsigned w;
		w = block_pos / 8;
		if (block_pos % 8 == 0) block_words[w] = '0;
		block_words[w][(7 - block_pos % 8) * 8 +: 8] = b;
		block_pos++;
		if (block_pos == 128) begin
			block_pos = 0;
			compress_block();
		end
	endtask

	task automatic start_message();
		for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
		block_pos  = 0;
		byte_count = '0;
	endtask

	// Absorbs one request; on end of message pads and queues the digest.
	task automatic predict_request(input logic [63:0] data, input logic [3:0] nb,
	                               input logic eom);
		int unsigned n;
		logic [63:0] bit_len;
		digest_word_t d;
		n = (nb > 8) ? 8 : nb;
		for (int i = 0; i < n; i++) begin
			absorb_byte(data[(7 - i) * 8 +: 8]);
			byte_count = byte_count + 1'b1;
		end
		if (eom) begin
			bit_len = {byte_count, 3'b000};
			absorb_byte(8'h80);
			while (block_pos != 112) absorb_byte(8'h00);
			for (int i = 0; i < 8; i++) absorb_byte(8'h00);
			for (int i = 0; i < 8; i++) absorb_byte(bit_len[(7 - i) * 8 +: 8]);
			for (int i = 0; i < 8; i++) begin
				d.word  = hash_state[i];
				d.index = 3'(i);
				d.last  = (i == 7);
				digest_q.push_back(d);
			end
			start_message();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_word_t d;
		if (!arst_n) begin
			start_message();
			digest_q.delete();
		end else begin
			if (in_valid && !in_stall)
				predict_request(chunk_data, valid_bytes, end_of_message);
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h index %0d",
					                          digest_word, digest_index));
				end else begin
					d = digest_q.pop_front();
					if (digest_word !== d.word)
						report_mismatch($sformatf("word %0d got %h want %h",
						                          d.index, digest_word, d.word));
					if (digest_index !== d.index)
						report_mismatch($sformatf("index got %0d want %0d",
						                          digest_index, d.index));
					if (last_word !== d.last)
						report_mismatch($sformatf("last_word on index %0d got %b want %b",
						                          d.index, last_word, d.last));
					if (d.last) digests_seen++;
				end
			end
		end
		pending = digest_q.size();
	end

endmodule

>>> sim/tb_sha512_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 message digest testbench
// Sends directed and random messages through the digest block under several
// idle and stall patterns; a checker beside the block predicts and compares
// every digest word.
// ----------------------------------------------------------------------------
module tb_sha512_message_digest;

	localparam int CycleLimit = 400000;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [63:0] chunk_data     = '0;
	logic [3:0]  valid_bytes    = '0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [63:0] digest_word;
	logic [2:0]  digest_index;
	logic        last_word;

	int errors, pending, digests_seen;
	int cycles       = 0;
	int requests     = 0;
	int send_idle    = 0;  // percent of cycles the sender leaves idle
	int recv_stall   = 0;  // percent of cycles the receiver stalls

	always #10 clk = ~clk;

	sha512_message_digest i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.chunk_data     (chunk_data),
		.valid_bytes    (valid_bytes),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digest_word    (digest_word),
		.digest_index   (digest_index),
		.last_word      (last_word)
	);

	sha512_digest_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.chunk_data     (chunk_data),
		.valid_bytes    (valid_bytes),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digest_word    (digest_word),
		.digest_index   (digest_index),
		.last_word      (last_word),
		.errors         (errors),
		.pending        (pending),
		.digests_seen   (digests_seen)
	);

	// The receiver stalls at random; the pattern is set per phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	// Watchdog: a run that stops making progress ends here as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles, pending);
			$display("tb_sha512_message_digest NOT OK");
			$finish;
		end
	end

	// Presents one request and returns at the edge that accepts it. Valid is
	// lowered only when the sender decides to idle, so back-to-back requests
	// keep it high without a second assignment in the same step. in_stall is
	// read at the falling edge, where it is stable until the next rising edge.
	task automatic send_request(input logic [63:0] data, input logic [3:0] nb,
	                            input logic eom);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid       <= 1'b1;
		chunk_data     <= data;
		valid_bytes    <= nb;
		end_of_message <= eom;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		requests++;
	endtask

	task automatic set_phase(input int idle_pct, input int stall_pct);
		send_idle  = idle_pct;
		recv_stall = stall_pct;
	endtask

	// A random message: mostly full chunks, with some short ones, some that
	// claim more than eight bytes (they saturate), and empty noise requests.
	task automatic send_random_message();
		int chunks;
		int unsigned pick;
		logic [3:0] nb;
		chunks = ($urandom_range(9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 12);
		for (int c = 0; c < chunks; c++) begin
			pick = $urandom_range(99);
			if (pick < 70)      nb = 4'd8;
			else if (pick < 85) nb = 4'($urandom_range(1, 7));
			else if (pick < 93) nb = 4'($urandom_range(9, 15));
			else                nb = 4'd0;
			send_request({$urandom, $urandom}, nb, 1'b0);
		end
		send_request({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling. The empty message gives the digest of
		// the empty string.
		set_phase(0, 0);
		send_request(64'h0, 4'd0, 1'b1);
		// The classic three-byte message, with junk in the bytes past the count.
		send_request(64'h616263_DEADBEEF_55, 4'd3, 1'b1);
		// An empty request that is not the end does nothing.
		send_request('1, 4'd0, 1'b0);
		// A count above eight saturates; all data bits high.
		send_request('1, 4'd15, 1'b1);
		// 112 bytes: the padding no longer fits and spills into a second
		// block; the message is closed by an empty end request.
		for (int i = 0; i < 14; i++) send_request({$urandom, $urandom}, 4'd8, 1'b0);
		send_request('1, 4'd0, 1'b1);
		// A single zero byte, and a full chunk of zeros ending a message.
		send_request(64'h0, 4'd1, 1'b1);
		send_request(64'h0, 4'd8, 1'b1);

		// Random part, through the idling phases in turn, each phase twice.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: set_phase(0, 0);
				1: set_phase(81, 0);
				2: set_phase(0, 81);
				default: set_phase(9, 9);
			endcase
			while (requests < 22 + (phase + 1) * 19) send_random_message();
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (200) @(posedge clk);

		$display("%0d requests sent, %0d digests checked across four idle and stall patterns",
		         requests, digests_seen);
		if (errors == 0) begin
			$display("tb_sha512_message_digest OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb_sha512_message_digest NOT OK");
		end
		$finish;
	end

endmodule
